>>> hdl/hpk_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// HPACK encoder package
// Request and field-kind codes, prefix constants, shared types and the
// integer-length helper used by the size check.
// ----------------------------------------------------------------------------
package hpk_pkg;

	// request types carried in tuser
	localparam logic [1:0] REQ_FIELD = 2'd0;
	localparam logic [1:0] REQ_STR   = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;
	localparam logic [1:0] REQ_SPARE = 2'd3;

	// header field representations
	localparam logic [1:0] KIND_INDEXED = 2'd0;
	localparam logic [1:0] KIND_INC     = 2'd1;
	localparam logic [1:0] KIND_PLAIN   = 2'd2;
	localparam logic [1:0] KIND_SPARE   = 2'd3;

	// first-byte patterns and prefix masks
	localparam logic [7:0] PFX_INDEXED = 8'h80;
	localparam logic [7:0] PFX_INC     = 8'h40;
	localparam logic [7:0] PFX_PLAIN   = 8'h00;
	localparam logic [7:0] PFX_STR     = 8'h00;
	localparam logic [7:0] LIM_7       = 8'h7F;
	localparam logic [7:0] LIM_6       = 8'h3F;
	localparam logic [7:0] LIM_4       = 8'h0F;
	localparam logic [7:0] CONT_BIT    = 8'h80;

	// one byte out of the integer serializer
	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} ser_out_t;

	// outcome of the block room check
	typedef struct packed {
		logic done;
		logic reject;
	} chk_res_t;

	function automatic logic [7:0] kind_pfx(input logic [1:0] kind);
		logic [7:0] p;
		case (kind)
			KIND_INDEXED: p = PFX_INDEXED;
			KIND_INC:     p = PFX_INC;
			default:      p = PFX_PLAIN;
		endcase
		return p;
	endfunction

	function automatic logic [7:0] kind_lim(input logic [1:0] kind);
		logic [7:0] l;
		case (kind)
			KIND_INDEXED: l = LIM_7;
			KIND_INC:     l = LIM_6;
			default:      l = LIM_4;
		endcase
		return l;
	endfunction

	// bytes taken by a prefixed integer (1 to 4 for a 16-bit value)
	function automatic logic [2:0] int_len(input logic [15:0] v, input logic [7:0] lim);
		logic [15:0] w;
		logic [2:0]  n;
		w = v - {8'd0, lim};
		if (v < {8'd0, lim})
			n = 3'd1;
		else if (w < 16'd128)
			n = 3'd2;
		else if (w < 16'd16384)
			n = 3'd3;
		else
			n = 3'd4;
		return n;
	endfunction

endpackage
`default_nettype wire

>>> hdl/hpk_int_ser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// HPACK integer serializer
// Emits a prefixed integer one byte per step, shifting the remainder
// seven bits at a time.
// ----------------------------------------------------------------------------
module hpk_int_ser
	import hpk_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        load,
	input  wire logic [7:0]  pfx,
	input  wire logic [7:0]  lim,
	input  wire logic [15:0] value,
	input  wire logic        step,
	output ser_out_t         ser
);

	logic [15:0] val_q;
	logic [7:0]  pfx_q;
	logic [7:0]  lim_q;
	logic        first_q;

	always_comb begin
		if (first_q) begin
			if (val_q < {8'd0, lim_q}) begin
				ser.data = pfx_q | val_q[7:0];
				ser.last = 1'b1;
			end else begin
				ser.data = pfx_q | lim_q;
				ser.last = 1'b0;
			end
		end else begin
			if (val_q < 16'd128) begin
				ser.data = val_q[7:0];
				ser.last = 1'b1;
			end else begin
				ser.data = CONT_BIT | {1'b0, val_q[6:0]};
				ser.last = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b1;
		end else if (load) begin
			first_q <= 1'b1;
		end else if (step) begin
			first_q <= 1'b0;
		end
	end

	// remainder shift register: drop the prefix limit first, then seven bits a step
	always_ff @(posedge clk) begin
		if (load) begin
			val_q <= value;
			pfx_q <= pfx;
			lim_q <= lim;
		end else if (step) begin
			if (first_q)
				val_q <= val_q - {8'd0, lim_q};
			else
				val_q <= {7'd0, val_q[15:7]};
		end
	end

endmodule
`default_nettype wire

>>> hdl/hpk_size_chk.sv
`default_nettype none
// ----------------------------------------------------------------------------
// HPACK field size check
// Two-stage check of a whole field's encoded size against the block room.
// ----------------------------------------------------------------------------
module hpk_size_chk
	import hpk_pkg::*;
#(
	parameter int MAX_STRING_LEN = 4096
)(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [1:0]  kind,
	input  wire logic [15:0] name_index,
	input  wire logic [12:0] name_len,
	input  wire logic [12:0] value_len,
	input  wire logic [15:0] used_count,
	input  wire logic [15:0] capacity,
	output chk_res_t         res
);

	logic        lit;
	logic        newname;
	logic [12:0] nlen_e;
	logic [12:0] vlen_e;
	logic [2:0]  hn;
	logic [2:0]  nn;
	logic [2:0]  vn;

	logic        valid_s1;
	logic [3:0]  hdr_sum_s1;
	logic [13:0] str_sum_s1;
	logic        too_long_s1;
	logic        valid_s2;
	logic        reject_s2;
	logic [17:0] total;

	always_comb begin
		lit     = (kind != KIND_INDEXED);
		newname = lit && (name_index == 16'd0);
		nlen_e  = newname ? name_len : 13'd0;
		vlen_e  = lit ? value_len : 13'd0;
		hn      = int_len(name_index, kind_lim(kind));
		nn      = newname ? int_len({3'd0, name_len}, LIM_7) : 3'd0;
		vn      = lit ? int_len({3'd0, value_len}, LIM_7) : 3'd0;
		total   = {2'd0, used_count} + {4'd0, str_sum_s1} + {14'd0, hdr_sum_s1};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= start;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		hdr_sum_s1  <= {1'b0, hn} + {1'b0, nn} + {1'b0, vn};
		str_sum_s1  <= {1'b0, nlen_e} + {1'b0, vlen_e};
		too_long_s1 <= ({4'd0, nlen_e} > 17'(MAX_STRING_LEN))
			|| ({4'd0, vlen_e} > 17'(MAX_STRING_LEN));
		reject_s2   <= too_long_s1 || (total > {2'd0, capacity});
	end

	assign res.done   = valid_s2;
	assign res.reject = reject_s2;

endmodule
`default_nettype wire

>>> hdl/hpack_header_field_encoder_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// HPACK header field encoder
// Builds an HPACK header block (no Huffman) from field descriptors and
// string bytes, with a running byte count limited by a capacity register.
// ----------------------------------------------------------------------------
// A request is accepted when the sequencer is idle and the output register
// is free or being emptied. String bytes pass one per cycle while the output
// is not stalled: a byte is accepted and lands in the output register in the
// same cycle, so a steady stream runs at one request per clock. A byte that
// ends a name is followed by its value length, one byte per cycle while the
// output is free. A descriptor is latched, passes the two-stage size check,
// then yields one encoded byte (up to seven) per cycle while the output is
// free, or the rejected result; the input is held off while the check runs
// and while these bytes are sent. The integer serializer emits a seven-bit
// digit per cycle while the output register is free, which sets the one-byte-per-cycle output rate.
// block_capacity may be written only while the block is idle.
// ----------------------------------------------------------------------------
module hpack_header_field_encoder_top
	import hpk_pkg::*;
#(
	parameter int MAX_STRING_LEN = 4096
)(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration: block_capacity
	input  wire logic        cfg_wen,
	input  wire logic [15:0] cfg_wdata,
	// request side
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// [15:0] name_index, [28:16] name_len, [41:29] value_len, [49:42] data_byte
	input  wire logic [55:0] s_tdata,
	// [1:0] req_type, [3:2] field_kind
	input  wire logic [3:0]  s_tuser,
	// result side
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [7:0] out_byte, [23:8] block_bytes
	output logic [23:0]      m_tdata,
	// [0] rejected
	output logic             m_tuser,
	output logic             m_tlast
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SIZE,
		ST_CHK,
		ST_REJ,
		ST_HDR,
		ST_NLEN,
		ST_VLEN
	} state_t;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_NAME,
		PH_VALUE
	} phase_t;

	state_t      state_q;
	phase_t      phase_q;
	logic [15:0] cap_q;
	logic [15:0] used_q;
	logic [12:0] left_q;
	logic [12:0] pend_q;
	logic        drop_q;

	// latched descriptor
	logic [1:0]  kind_q;
	logic [15:0] idx_q;
	logic [12:0] nlen_q;
	logic [12:0] vlen_q;

	// output register
	logic        m_tvalid_q;
	logic [7:0]  obyte_q;
	logic [15:0] obytes_q;
	logic        orej_q;
	logic        olast_q;

	logic [1:0]  req_type;
	logic [1:0]  field_kind;
	logic [15:0] name_index;
	logic [12:0] name_len;
	logic [12:0] value_len;
	logic [7:0]  data_byte;

	logic        out_free;
	logic        out_load;
	logic        in_acc;
	logic        str_hit;
	logic        newname;
	logic [15:0] used_inc;

	logic        ser_load;
	logic [7:0]  ser_pfx;
	logic [7:0]  ser_lim;
	logic [15:0] ser_val;
	logic        ser_step;
	ser_out_t    ser;
	chk_res_t    chk;

	assign req_type   = s_tuser[1:0];
	assign field_kind = s_tuser[3:2];
	assign name_index = s_tdata[15:0];
	assign name_len   = s_tdata[28:16];
	assign value_len  = s_tdata[41:29];
	assign data_byte  = s_tdata[49:42];

	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE) && out_free;
	assign in_acc   = s_tvalid && s_tready;
	// a string byte that belongs to a pending name or value
	assign str_hit  = in_acc && (req_type == REQ_STR) && (phase_q != PH_IDLE)
		&& (left_q != 13'd0);
	assign newname  = (kind_q != KIND_INDEXED) && (idx_q == 16'd0);
	assign used_inc = used_q + 16'd1;
	// a new result enters the output register this cycle
	assign out_load = ((state_q == ST_IDLE) && str_hit && !drop_q)
		|| (((state_q == ST_REJ) || (state_q == ST_HDR) || (state_q == ST_NLEN)
		|| (state_q == ST_VLEN)) && out_free);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {obytes_q, obyte_q};
	assign m_tuser  = orej_q;
	assign m_tlast  = olast_q;

	// serializer loading: header, then name length, then value length
	always_comb begin
		ser_load = 1'b0;
		ser_pfx  = PFX_STR;
		ser_lim  = LIM_7;
		ser_val  = {3'd0, vlen_q};
		ser_step = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (str_hit && (left_q == 13'd1) && (phase_q == PH_NAME) && !drop_q) begin
					ser_load = 1'b1;
					ser_val  = {3'd0, pend_q};
				end
			end
			ST_CHK: begin
				if (chk.done && !chk.reject) begin
					ser_load = 1'b1;
					ser_pfx  = kind_pfx(kind_q);
					ser_lim  = kind_lim(kind_q);
					ser_val  = idx_q;
				end
			end
			ST_HDR: begin
				ser_step = out_free;
				if (out_free && ser.last && (kind_q != KIND_INDEXED)) begin
					ser_load = 1'b1;
					ser_val  = newname ? {3'd0, nlen_q} : {3'd0, vlen_q};
				end
			end
			ST_NLEN: begin
				ser_step = out_free;
				if (out_free && ser.last && (nlen_q == 13'd0))
					ser_load = 1'b1;
			end
			ST_VLEN: begin
				ser_step = out_free;
			end
			default: begin
			end
		endcase
	end

	hpk_int_ser u_ser (
		.clk   (clk),
		.arst_n(arst_n),
		.load  (ser_load),
		.pfx   (ser_pfx),
		.lim   (ser_lim),
		.value (ser_val),
		.step  (ser_step),
		.ser   (ser)
	);

	hpk_size_chk #(
		.MAX_STRING_LEN(MAX_STRING_LEN)
	) u_chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (state_q == ST_SIZE),
		.kind      (kind_q),
		.name_index(idx_q),
		.name_len  (nlen_q),
		.value_len (vlen_q),
		.used_count(used_q),
		.capacity  (cap_q),
		.res       (chk)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			phase_q    <= PH_IDLE;
			cap_q      <= 16'd4096;
			used_q     <= 16'd0;
			left_q     <= 13'd0;
			pend_q     <= 13'd0;
			drop_q     <= 1'b0;
			kind_q     <= KIND_INDEXED;
			idx_q      <= 16'd0;
			nlen_q     <= 13'd0;
			vlen_q     <= 13'd0;
			m_tvalid_q <= 1'b0;
			obyte_q    <= 8'd0;
			obytes_q   <= 16'd0;
			orej_q     <= 1'b0;
			olast_q    <= 1'b0;
		end else begin
			if (cfg_wen)
				cap_q <= cfg_wdata;
			// hold the result until taken; a new one replaces it
			if (out_load)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						unique case (req_type)
							REQ_FIELD: begin
								if (field_kind != KIND_SPARE) begin
									// abandon any pending string and latch the field
									phase_q <= PH_IDLE;
									left_q  <= 13'd0;
									pend_q  <= 13'd0;
									drop_q  <= 1'b0;
									kind_q  <= field_kind;
									idx_q   <= name_index;
									nlen_q  <= name_len;
									vlen_q  <= value_len;
									state_q <= ST_SIZE;
								end
							end
							REQ_STR: begin
								if (str_hit) begin
									if (!drop_q) begin
										used_q     <= used_inc;
										obyte_q    <= data_byte;
										obytes_q   <= used_inc;
										orej_q     <= 1'b0;
										olast_q    <= !((left_q == 13'd1) && (phase_q == PH_NAME));
									end
									if (left_q == 13'd1) begin
										if (phase_q == PH_NAME && !drop_q) begin
											// name done: value length follows
											phase_q <= PH_IDLE;
											left_q  <= 13'd0;
											state_q <= ST_VLEN;
										end else if (phase_q == PH_NAME) begin
											left_q  <= pend_q;
											phase_q <= (pend_q != 13'd0) ? PH_VALUE : PH_IDLE;
											drop_q  <= (pend_q != 13'd0);
										end else begin
											phase_q <= PH_IDLE;
											left_q  <= 13'd0;
											drop_q  <= 1'b0;
										end
									end else begin
										left_q <= left_q - 13'd1;
									end
								end
							end
							REQ_CLEAR: begin
								used_q  <= 16'd0;
								phase_q <= PH_IDLE;
								left_q  <= 13'd0;
								pend_q  <= 13'd0;
								drop_q  <= 1'b0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_SIZE: begin
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					if (chk.done) begin
						if (chk.reject) begin
							state_q <= ST_REJ;
						end else begin
							if (kind_q != KIND_INDEXED)
								pend_q <= vlen_q;
							state_q <= ST_HDR;
						end
					end
				end
				ST_REJ: begin
					if (out_free) begin
						obyte_q    <= 8'd0;
						obytes_q   <= used_q;
						orej_q     <= 1'b1;
						olast_q    <= 1'b1;
						state_q    <= ST_IDLE;
						if (kind_q != KIND_INDEXED) begin
							// consume the field's strings without output
							pend_q <= vlen_q;
							if (newname && (nlen_q != 13'd0)) begin
								phase_q <= PH_NAME;
								left_q  <= nlen_q;
								drop_q  <= 1'b1;
							end else begin
								left_q  <= vlen_q;
								phase_q <= (vlen_q != 13'd0) ? PH_VALUE : PH_IDLE;
								drop_q  <= (vlen_q != 13'd0);
							end
						end
					end
				end
				ST_HDR: begin
					if (out_free) begin
						used_q     <= used_inc;
						obyte_q    <= ser.data;
						obytes_q   <= used_inc;
						orej_q     <= 1'b0;
						olast_q    <= ser.last && (kind_q == KIND_INDEXED);
						if (ser.last) begin
							if (kind_q == KIND_INDEXED)
								state_q <= ST_IDLE;
							else if (newname)
								state_q <= ST_NLEN;
							else
								state_q <= ST_VLEN;
						end
					end
				end
				ST_NLEN: begin
					if (out_free) begin
						used_q     <= used_inc;
						obyte_q    <= ser.data;
						obytes_q   <= used_inc;
						orej_q     <= 1'b0;
						olast_q    <= ser.last && (nlen_q != 13'd0);
						if (ser.last) begin
							if (nlen_q != 13'd0) begin
								phase_q <= PH_NAME;
								left_q  <= nlen_q;
								state_q <= ST_IDLE;
							end else begin
								state_q <= ST_VLEN;
							end
						end
					end
				end
				ST_VLEN: begin
					if (out_free) begin
						used_q     <= used_inc;
						obyte_q    <= ser.data;
						obytes_q   <= used_inc;
						orej_q     <= 1'b0;
						olast_q    <= ser.last;
						if (ser.last) begin
							left_q  <= pend_q;
							phase_q <= (pend_q != 13'd0) ? PH_VALUE : PH_IDLE;
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef ASSERT_OFF
	// a pending string always has bytes left, and only a pending string has
	a_phase_left: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_IDLE) == (left_q == 13'd0))
		else $error("string phase and byte count disagree");

	a_drop_phase: assert property (@(posedge clk) disable iff (!arst_n)
		drop_q |-> (phase_q != PH_IDLE))
		else $error("dropping with no string pending");

	a_rej_form: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && orej_q) |-> ((obyte_q == 8'd0) && olast_q))
		else $error("rejected result malformed");

	a_chk_state: assert property (@(posedge clk) disable iff (!arst_n)
		chk.done |-> (state_q == ST_CHK))
		else $error("size check finished outside its wait state");
`endif

endmodule
`default_nettype wire
